[sv/sru_pkg.sv]
// ----------------------------------------------------------------------------
// sru_pkg: shared types and constants of the string record decoder
// Holds the command format that the parser hands to the byte encoder,
// and the depth of the command queue between them.
// ----------------------------------------------------------------------------
package sru_pkg;

    // Depth of the command queue between the parser and the encoder.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // What the encoder does with one command.
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,   // pass the low byte through
        CMD_UNIT  = 2'd1,   // encode a 16-bit unit as 1 to 3 UTF-8 bytes
        CMD_EMPTY = 2'd2    // one result flagged as an empty string
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] data;
        logic        last;
    } t_cmd;

    // Queue status seen by the parser and the encoder.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // UTF-8 encoding constants.
    localparam logic [15:0] LIM_1BYTE = 16'h0080;
    localparam logic [15:0] LIM_2BYTE = 16'h0800;
    localparam logic [7:0]  LEAD_2    = 8'hC0;
    localparam logic [7:0]  LEAD_3    = 8'hE0;
    localparam logic [7:0]  CONT      = 8'h80;

endpackage

[sv/string_record_to_utf8_decoder.sv]
// ----------------------------------------------------------------------------
// string_record_to_utf8_decoder: string pool record to UTF-8 decoder
// Parses length-prefixed UTF-16 or UTF-8 string records and streams the
// decoded string out as UTF-8 bytes.
// ----------------------------------------------------------------------------
// Both sides look like a queue. Push a unit while full is low; pop a byte
// while empty is low. A parser takes one unit in every cycle while the
// command queue has room, and queues at most one command per unit in a
// four-entry command queue. An encoder behind it turns each command into
// bytes, one byte per cycle while the result register is free or popped,
// into a single result register, so a stalled consumer never blocks the
// parser until the queue fills. A UTF-16 data unit is encoded as one byte
// below 0x80, two below 0x800 and three otherwise; a UTF-8 data byte
// yields one byte. The result register bounds the sustained rate; length
// prefixes add no output bytes. Each surrogate unit is encoded on its own as
// three bytes. A record with a zero length yields a single result with
// empty_string and last_byte set and a zero byte; later units of that
// record are dropped. A unit with record_start always begins a new record,
// and the mode register is sampled at that point. The mode register is
// written through a valid/ready channel that is always ready, and it should
// only be written while no transaction is still in flight.
// ----------------------------------------------------------------------------
module string_record_to_utf8_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_utf8_mode,
    // Input queue side.
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_unit,
    input  logic        i_record_start,
    // Result queue side.
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic        o_empty_string
);
    import sru_pkg::*;

    logic       r_utf8_mode;
    logic       accept;
    logic       cmd_valid;
    t_cmd       cmd_in;
    t_cmd       cmd_head;
    t_fifo_stat stat;
    logic       cmd_pop;

    // The mode register accepts a transaction in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_utf8_mode <= i_cfg_utf8_mode;
        end
    end

    // A unit is taken whenever the command queue has room, even when the
    // unit ends up producing no command.
    assign full   = stat.full;
    assign accept = push && !stat.full;

    sru_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_unit         (i_unit),
        .i_record_start (i_record_start),
        .i_utf8_mode    (r_utf8_mode),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd_in)
    );

    sru_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_wdata (cmd_in),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_head),
        .o_stat  (stat)
    );

    sru_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_head),
        .i_cmd_empty    (stat.empty),
        .o_cmd_pop      (cmd_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte),
        .o_empty_string (o_empty_string)
    );

endmodule

[sv/sru_front.sv]
// ----------------------------------------------------------------------------
// sru_front: record parser
// Tracks the length prefix of each string record and turns every accepted
// unit into at most one command for the encoder.
// ----------------------------------------------------------------------------
module sru_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [15:0]   i_unit,
    input  logic          i_record_start,
    input  logic          i_utf8_mode,
    output logic          o_cmd_valid,
    output sru_pkg::t_cmd o_cmd
);
    import sru_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_W_LEN2  = 3'd1,
        PH_W_DATA  = 3'd2,
        PH_B_CLEN2 = 3'd3,
        PH_B_BLEN1 = 3'd4,
        PH_B_BLEN2 = 3'd5,
        PH_B_DATA  = 3'd6,
        PH_DONE    = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [14:0] r_hlp, n_hlp;
    logic [30:0] r_rem, n_rem;
    logic        r_ccz, n_ccz;

    logic [30:0] rem_dec;
    logic [30:0] count_long;
    logic [14:0] bytes_long;
    logic [7:0]  b;

    assign b          = i_unit[7:0];
    assign rem_dec    = r_rem - 31'd1;
    assign count_long = {r_hlp, i_unit};
    assign bytes_long = {r_hlp[6:0], b};

    always_comb begin
        n_phase     = r_phase;
        n_hlp       = r_hlp;
        n_rem       = r_rem;
        n_ccz       = r_ccz;
        o_cmd_valid = 1'b0;
        o_cmd       = '{kind: CMD_BYTE, data: i_unit, last: 1'b0};

        if (i_record_start) begin
            n_hlp = '0;
            n_rem = '0;
            n_ccz = 1'b0;
            if (!i_utf8_mode) begin
                if (i_unit[15]) begin
                    n_hlp   = i_unit[14:0];
                    n_phase = PH_W_LEN2;
                end else if (i_unit[14:0] == 15'd0) begin
                    o_cmd_valid = 1'b1;
                    o_cmd       = '{kind: CMD_EMPTY, data: 16'd0, last: 1'b1};
                    n_phase     = PH_DONE;
                end else begin
                    n_rem   = {16'd0, i_unit[14:0]};
                    n_phase = PH_W_DATA;
                end
            end else if (b[7]) begin
                n_hlp   = {8'd0, b[6:0]};
                n_phase = PH_B_CLEN2;
            end else begin
                n_ccz   = (b == 8'd0);
                n_phase = PH_B_BLEN1;
            end
        end else begin
            unique case (r_phase)
                PH_W_LEN2: begin
                    if (count_long == 31'd0) begin
                        o_cmd_valid = 1'b1;
                        o_cmd       = '{kind: CMD_EMPTY, data: 16'd0, last: 1'b1};
                        n_rem       = '0;
                        n_phase     = PH_DONE;
                    end else begin
                        n_rem   = count_long;
                        n_phase = PH_W_DATA;
                    end
                end
                PH_W_DATA: begin
                    n_rem       = rem_dec;
                    o_cmd_valid = 1'b1;
                    o_cmd       = '{kind: CMD_UNIT, data: i_unit, last: (rem_dec == 31'd0)};
                    if (rem_dec == 31'd0) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_B_CLEN2: begin
                    n_ccz   = (bytes_long == 15'd0);
                    n_phase = PH_B_BLEN1;
                end
                PH_B_BLEN1, PH_B_BLEN2: begin
                    if (r_phase == PH_B_BLEN1 && b[7]) begin
                        n_hlp   = {8'd0, b[6:0]};
                        n_phase = PH_B_BLEN2;
                    end else begin
                        // Byte count is complete: either a short one or a long one.
                        if (r_phase == PH_B_BLEN1) begin
                            n_rem = {23'd0, b};
                        end else begin
                            n_rem = {16'd0, bytes_long};
                        end
                        if (r_ccz || n_rem == 31'd0) begin
                            o_cmd_valid = 1'b1;
                            o_cmd       = '{kind: CMD_EMPTY, data: 16'd0, last: 1'b1};
                            n_rem       = '0;
                            n_phase     = PH_DONE;
                        end else begin
                            n_phase = PH_B_DATA;
                        end
                    end
                end
                PH_B_DATA: begin
                    n_rem       = rem_dec;
                    o_cmd_valid = 1'b1;
                    o_cmd       = '{kind: CMD_BYTE, data: {8'd0, b},
                                    last: (rem_dec == 31'd0)};
                    if (rem_dec == 31'd0) begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (!i_accept) begin
            o_cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hlp   <= '0;
            r_rem   <= '0;
            r_ccz   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hlp   <= n_hlp;
            r_rem   <= n_rem;
            r_ccz   <= n_ccz;
        end
    end

endmodule

[sv/sru_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// sru_cmd_fifo: command queue
// A small register queue that lets the parser run ahead of the encoder.
// ----------------------------------------------------------------------------
module sru_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sru_pkg::t_cmd       i_wdata,
    input  logic                i_pop,
    output sru_pkg::t_cmd       o_rdata,
    output sru_pkg::t_fifo_stat o_stat
);
    import sru_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wptr, r_rptr;
    logic [CMD_AW:0]   r_count;

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == (CMD_AW)'(CMD_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == (CMD_AW)'(CMD_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/sru_back.sv]
// ----------------------------------------------------------------------------
// sru_back: UTF-8 byte encoder
// Takes commands from the queue and, while the result register is free or
// popped, emits one byte per cycle into it for the consumer to drain.
// ----------------------------------------------------------------------------
module sru_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sru_pkg::t_cmd       i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic                o_last_byte,
    output logic                o_empty_string
);
    import sru_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_emp;

    logic [1:0] nb_m1;      // byte count of the head command, minus one
    logic [7:0] sel_byte;
    logic       final_byte;
    logic       load;

    always_comb begin
        nb_m1    = 2'd0;
        sel_byte = i_cmd.data[7:0];
        if (i_cmd.kind == CMD_UNIT) begin
            if (i_cmd.data < LIM_1BYTE) begin
                nb_m1 = 2'd0;
            end else if (i_cmd.data < LIM_2BYTE) begin
                nb_m1 = 2'd1;
                sel_byte = (r_idx == 2'd0) ? (LEAD_2 | {3'd0, i_cmd.data[10:6]})
                                           : (CONT | {2'd0, i_cmd.data[5:0]});
            end else begin
                nb_m1 = 2'd2;
                case (r_idx)
                    2'd0:    sel_byte = LEAD_3 | {4'd0, i_cmd.data[15:12]};
                    2'd1:    sel_byte = CONT | {2'd0, i_cmd.data[11:6]};
                    default: sel_byte = CONT | {2'd0, i_cmd.data[5:0]};
                endcase
            end
        end
    end

    assign final_byte = (r_idx == nb_m1);
    assign load       = !i_cmd_empty && (!r_valid || i_pop);
    assign o_cmd_pop  = load && final_byte;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= i_cmd.last && final_byte;
            r_emp  <= (i_cmd.kind == CMD_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= final_byte ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_byte;
    assign o_last_byte    = r_last;
    assign o_empty_string = r_emp;

endmodule

[sv/sru_checker.sv]
// ----------------------------------------------------------------------------
// sru_checker: port-level checks of the string record decoder
// Watches the ports of the top level and flags behavior that a correct
// decoder never shows.
// ----------------------------------------------------------------------------
module sru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_cfg_utf8_mode,
    input logic        push,
    input logic        full,
    input logic [15:0] i_unit,
    input logic        i_record_start,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic        o_last_byte,
    input logic        o_empty_string
);

    // Right after reset nothing is queued on either side.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    // An empty-string result is the only, and so the final, one of its record.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_empty_string) |-> (o_last_byte && o_out_byte == 8'd0))
        else $error("empty-string result without last flag or with data");

    // A full input side means commands wait, so a result must be on offer.
    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input stalled while no result is offered");

    // A result that is not taken stays in place.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)
                              && $stable(o_last_byte) && $stable(o_empty_string)))
        else $error("waiting result changed");

endmodule

bind string_record_to_utf8_decoder sru_checker u_sru_checker (.*);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for string_record_to_utf8_decoder
// Sends UTF-16 and UTF-8 string records through the input queue and checks
// every popped byte. A transaction-level predictor mirrors the record
// parser and the UTF-8 encoder and holds the bytes the decoder still owes.
// The bench runs a directed pass over the boundary cases and then random
// records in both modes, with random gaps on both sides, a stretch with no
// gaps and one long hold-off on the result side.
// ----------------------------------------------------------------------------
import sru_pkg::*;

// One popped byte with its record flags.
typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_empty;
} utf8_byte_t;

// Predicts the byte stream of the decoder and checks popped bytes against it.
class utf8_byte_predictor;

    typedef enum logic [2:0] {
        PH_IDLE,     // waiting for a record start
        PH_LEN_LO,   // UTF-16: low half of a long character count
        PH_UNITS,    // UTF-16: data units
        PH_CC_LO,    // UTF-8: low byte of a long character count
        PH_BC_HI,    // UTF-8: first byte of the byte count
        PH_BC_LO,    // UTF-8: low byte of a long byte count
        PH_BYTES,    // UTF-8: data bytes
        PH_DONE      // record finished, units ignored
    } rec_phase_t;

    logic        utf8_mode;
    rec_phase_t  phase;
    logic [14:0] len_high;
    logic [30:0] units_left;
    logic        char_count_zero;
    utf8_byte_t  pending_bytes[$];
    int          mismatches;

    function new();
        utf8_mode       = 1'b0;
        phase           = PH_IDLE;
        len_high        = '0;
        units_left      = '0;
        char_count_zero = 1'b0;
        mismatches      = 0;
    endfunction

    function void set_mode(input logic m);
        utf8_mode = m;
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

    function void add_byte(input logic [7:0] b, input logic last, input logic emp);
        utf8_byte_t r;
        r.data     = b;
        r.last     = last;
        r.is_empty = emp;
        pending_bytes.push_back(r);
    endfunction

    function void empty_record();
        add_byte(8'h00, 1'b1, 1'b1);
        phase      = PH_DONE;
        units_left = '0;
    endfunction

    function void start_units(input logic [30:0] n);
        if (n == '0) begin
            empty_record();
        end else begin
            units_left = n;
            phase      = PH_UNITS;
        end
    endfunction

    function void start_bytes(input logic [14:0] n);
        if (char_count_zero || n == '0) begin
            empty_record();
        end else begin
            units_left = {16'b0, n};
            phase      = PH_BYTES;
        end
    endfunction

    // Surrogates fall in the three-byte branch like any other unit.
    function void encode_unit(input logic [15:0] c, input logic last);
        if (c < LIM_1BYTE) begin
            add_byte(c[7:0], last, 1'b0);
        end else if (c < LIM_2BYTE) begin
            add_byte(LEAD_2 | {3'b0, c[10:6]}, 1'b0, 1'b0);
            add_byte(CONT | {2'b0, c[5:0]}, last, 1'b0);
        end else begin
            add_byte(LEAD_3 | {4'b0, c[15:12]}, 1'b0, 1'b0);
            add_byte(CONT | {2'b0, c[11:6]}, 1'b0, 1'b0);
            add_byte(CONT | {2'b0, c[5:0]}, last, 1'b0);
        end
    endfunction

    // Called for every input transaction.
    function void note_unit(input logic [15:0] u, input logic s);
        logic last;
        if (s) begin
            len_high        = '0;
            units_left      = '0;
            char_count_zero = 1'b0;
            if (!utf8_mode) begin
                if (u[15]) begin
                    len_high = u[14:0];
                    phase    = PH_LEN_LO;
                end else begin
                    start_units({16'b0, u[14:0]});
                end
            end else if (u[7]) begin
                len_high = {8'b0, u[6:0]};
                phase    = PH_CC_LO;
            end else begin
                char_count_zero = (u[7:0] == 8'h00);
                phase           = PH_BC_HI;
            end
        end else begin
            case (phase)
                PH_LEN_LO: begin
                    start_units({len_high, u});
                end
                PH_UNITS: begin
                    units_left = units_left - 1'b1;
                    last = (units_left == '0);
                    if (last) phase = PH_DONE;
                    encode_unit(u, last);
                end
                PH_CC_LO: begin
                    char_count_zero = ({len_high[6:0], u[7:0]} == 15'd0);
                    phase           = PH_BC_HI;
                end
                PH_BC_HI: begin
                    if (u[7]) begin
                        len_high = {8'b0, u[6:0]};
                        phase    = PH_BC_LO;
                    end else begin
                        start_bytes({7'b0, u[7:0]});
                    end
                end
                PH_BC_LO: begin
                    start_bytes({len_high[6:0], u[7:0]});
                end
                PH_BYTES: begin
                    units_left = units_left - 1'b1;
                    last = (units_left == '0);
                    if (last) phase = PH_DONE;
                    add_byte(u[7:0], last, 1'b0);
                end
                default: begin
                end
            endcase
        end
    endfunction

    // Called for every result transaction.
    function void check_byte(input logic [7:0] b, input logic last, input logic emp);
        utf8_byte_t exp_byte;
        if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected byte %02h last %0b empty %0b", b, last, emp);
            return;
        end
        exp_byte = pending_bytes.pop_front();
        if (b !== exp_byte.data || last !== exp_byte.last || emp !== exp_byte.is_empty) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected byte %02h last %0b empty %0b, got %02h %0b %0b",
                         exp_byte.data, exp_byte.last, exp_byte.is_empty, b, last, emp);
        end
    endfunction

endclass

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction before the run is declared hung. The
    // longest honest pause is the receiver hold-off plus the settle time.
    localparam int STALL_LIMIT  = 3000;
    // Settle time after the last expected byte, covering the parser, the
    // command queue and the result register.
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_OFF      = 120;
    localparam int PHASE_UNITS   = 50;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_utf8_mode = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] i_unit = '0;
    logic        i_record_start = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic        o_empty_string;

    utf8_byte_predictor decoder_model = new();

    // Bench state; no_idle and hold_cycles are shared between the stimulus and the receiver process.
    bit no_idle     = 1'b0;
    int hold_cycles = 0;
    int units_sent  = 0;
    int stall_cycles = 0;

    // Mode of each random phase; both extremes appear and repeat.
    bit phase_modes [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    string_record_to_utf8_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_utf8_mode(i_cfg_utf8_mode),
        .push           (push),
        .full           (full),
        .i_unit         (i_unit),
        .i_record_start (i_record_start),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte),
        .o_empty_string (o_empty_string)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Transactions are observed at the rising edge. An input is noted
    // before a result is checked, although a result can never come out at
    // the same edge as the unit that causes it. Any transaction clears the
    // hang counter.
    always @(posedge i_clk) begin
        if (push && !full)
            decoder_model.note_unit(i_unit, i_record_start);
        if (pop && !empty)
            decoder_model.check_byte(o_out_byte, o_last_byte, o_empty_string);
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[string_record_to_utf8_decoder] ERROR");
            $finish;
        end
    end

    // Result side. Pop drops with a chance of about six in a hundred, never
    // while the no-idle stretch runs, and stays low through a requested hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles--;
        end else begin
            pop <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    // Every driving task starts and ends just after a falling edge.
    task automatic send_unit(input logic [15:0] u, input logic s);
        while (!no_idle && $urandom_range(99) < 6) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_unit         <= u;
        i_record_start <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        units_sent++;
        @(negedge i_clk);
    endtask

    // Waits until every expected byte has been popped, then lets the block
    // settle so that no unit is still in the parser.
    task automatic wait_idle();
        push <= 1'b0;
        while (decoder_model.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_valid     <= 1'b1;
        i_cfg_utf8_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        decoder_model.set_mode(m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Data units are drawn from each encoding class, surrogates included.
    function automatic logic [15:0] pick_utf16_unit();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(16'h007F, 0));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hDFFF, 16'hD800));
            default: return 16'($urandom_range(16'hFFFF, 0));
        endcase
    endfunction

    // A UTF-16 record with a short or long count. A few records carry a
    // huge count or are cut short, so that the next start breaks them off,
    // and a few are followed by a stray unit that must be ignored.
    task automatic send_utf16_record();
        int          n;
        int          n_sent;
        int          r;
        logic [14:0] hi;
        n  = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        r  = $urandom_range(99);
        hi = '0;
        if (r < 12) begin
            if (r < 2) hi = 15'($urandom_range(15'h7FFF, 1));
            send_unit({1'b1, hi}, 1'b1);
            send_unit(16'(n), 1'b0);
        end else begin
            send_unit(16'(n), 1'b1);
        end
        n_sent = ($urandom_range(9) == 0) ? $urandom_range(n, 0) : n;
        for (int i = 0; i < n_sent; i++)
            send_unit(pick_utf16_unit(), 1'b0);
        if ($urandom_range(9) == 0)
            send_unit(16'($urandom), 1'b0);
    endtask

    // A UTF-8 record. The upper byte of every unit is random and must be
    // ignored. Counts come in the short and the long form, zero now and then.
    task automatic send_utf8_record();
        int         chars;
        int         n;
        int         n_sent;
        logic [7:0] junk;
        chars = ($urandom_range(9) == 0) ? 0 : $urandom_range(16'h7FFF, 1);
        n     = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        junk  = 8'($urandom);
        if ($urandom_range(99) < 15) begin
            send_unit({junk, 1'b1, 7'(chars >> 8)}, 1'b1);
            send_unit({8'($urandom), 8'(chars)}, 1'b0);
        end else begin
            send_unit({junk, 1'b0, 7'(chars)}, 1'b1);
        end
        if ($urandom_range(99) < 15) begin
            send_unit({8'($urandom), 8'h80}, 1'b0);
            send_unit({8'($urandom), 8'(n)}, 1'b0);
        end else begin
            send_unit({8'($urandom), 8'(n)}, 1'b0);
        end
        n_sent = ($urandom_range(9) == 0) ? $urandom_range(n, 0) : n;
        for (int i = 0; i < n_sent; i++)
            send_unit(16'($urandom), 1'b0);
        if ($urandom_range(9) == 0)
            send_unit(16'($urandom), 1'b0);
    endtask

    initial begin
        int phase_start;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // UTF-16 mode, written explicitly even though it is the reset value.
        write_mode(1'b0);

        // One-, two- and three-byte units, with the zero unit in the data.
        send_unit(16'h0003, 1'b1);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // Long count, the two-byte boundary and a high surrogate.
        send_unit(16'h8000, 1'b1);
        send_unit(16'h0002, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'hD800, 1'b0);
        // Zero count gives the empty result; the stray unit is dropped.
        send_unit(16'h0000, 1'b1);
        send_unit(16'h1234, 1'b0);
        // Largest count, broken off by a new record with a low surrogate.
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0001, 1'b1);
        send_unit(16'hDFFF, 1'b0);
        // Long count of zero.
        send_unit(16'h8000, 1'b1);
        send_unit(16'h0000, 1'b0);
        // The mode changes in the middle of a record; the record finishes
        // in the mode it started in.
        send_unit(16'h0002, 1'b1);
        send_unit(16'h0041, 1'b0);
        wait_idle();
        write_mode(1'b1);
        send_unit(16'h00E9, 1'b0);

        // UTF-8: junk upper bytes, a long byte count, bytes with bit 7 set.
        send_unit(16'hAB02, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h5502, 1'b0);
        send_unit(16'hFF00, 1'b0);
        send_unit(16'h00FF, 1'b0);
        // Long character count of zero makes the record empty.
        send_unit(16'h0080, 1'b1);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0003, 1'b0);
        // Largest counts; the next record start breaks this one off.
        send_unit(16'h00FF, 1'b1);
        send_unit(16'h00FF, 1'b0);
        send_unit(16'h00FF, 1'b0);
        send_unit(16'h00FF, 1'b0);
        send_unit(16'h0061, 1'b0);

        // Random records. The first phase opens with a long hold-off on the
        // result side so the queues fill and push is refused; the third
        // phase runs with no idle cycles on either side.
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_mode(phase_modes[p]);
            if (p == 0) hold_cycles = HOLD_OFF;
            no_idle     = (p == 2);
            phase_start = units_sent;
            while (units_sent - phase_start < PHASE_UNITS) begin
                if (phase_modes[p])
                    send_utf8_record();
                else
                    send_utf16_record();
            end
        end
        no_idle = 1'b0;
        wait_idle();

        if (decoder_model.mismatches == 0 && decoder_model.pending() == 0)
            $display("[string_record_to_utf8_decoder] OK");
        else
            $display("[string_record_to_utf8_decoder] ERROR");
        $finish;
    end

endmodule
